@@ rtl/vlsr_pkg.sv @@
`timescale 1ns / 1ps

package vlsr_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int OMEGA_WIDTH  = 16;

    // unit weight in Q1.14
    localparam logic signed [OMEGA_WIDTH-1:0] OMEGA_ONE = 16'sd16384;

    // derived widths
    localparam int DIFF_WIDTH = SAMPLE_WIDTH + 1;
    localparam int SUM_WIDTH  = SAMPLE_WIDTH + 1;
    localparam int QUOT_WIDTH = SAMPLE_WIDTH + 1;
    localparam int M_WIDTH    = SAMPLE_WIDTH + 15;
    localparam int MLO_WIDTH  = (M_WIDTH + 1) / 2;
    localparam int MHI_WIDTH  = M_WIDTH - MLO_WIDTH;
    localparam int PROD_WIDTH = M_WIDTH + SAMPLE_WIDTH;
    localparam int X_WIDTH    = PROD_WIDTH - 14;
    localparam int REM_WIDTH  = SAMPLE_WIDTH + 1;

    localparam logic [1:0] FILL_FULL = 2'd2;

    // control and side data carried down the pipe
    typedef struct packed {
        logic                           valid;
        logic                           ok;
        logic                           neg;
        logic signed [SAMPLE_WIDTH-1:0] centre;
        logic [SAMPLE_WIDTH-1:0]        b;
        logic [SUM_WIDTH-1:0]           s;
    } t_carry;

    typedef struct packed {
        logic [REM_WIDTH-1:0]  rem;
        logic [QUOT_WIDTH-1:0] xlo;
        logic [QUOT_WIDTH-1:0] q;
    } t_div;

endpackage

@@ rtl/van_leer_limited_slope_reconstruction_unit.sv @@
`timescale 1ns / 1ps
// van leer limited slope reconstruction (muscl)
// input channel: i_valid / o_stall carry one beat per cell value (i_sample,
// i_row_start). i_row_start clears the three-cell window; the first two beats of
// a row give no result, every later beat gives exactly one result for the cell
// before it (slope, left and right edge, saturated flag).
// output channel: o_valid / i_stall, fed from an output register.
// throughput: one beat per cycle while the output is not stalled. the pipe has
// six arithmetic stages (differences, magnitudes, weight products, blend,
// split 47x32 product, dividend) and the 33-stage restoring divider, one
// quotient bit per stage, plus the output register.
// omega is written through i_omega_we / i_omega_wdata and clamped to +-1.0;
// write it only while no beat is in flight.
// reset (synchronous, active low) empties the pipe, clears the window and
// sets omega to zero.
// a stall on the output freezes the whole pipe and raises o_stall, so no beat
// is lost or repeated.
module van_leer_limited_slope_reconstruction_unit
    import vlsr_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_omega_we,
    input  logic signed [OMEGA_WIDTH-1:0]  i_omega_wdata,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                           i_row_start,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_slope,
    output logic signed [SAMPLE_WIDTH-1:0] o_left_edge,
    output logic signed [SAMPLE_WIDTH-1:0] o_right_edge,
    output logic                           o_saturated
);

    localparam int W = SAMPLE_WIDTH;

    // saturate a wide signed value to the sample range, flag in the top bit
    function automatic logic [W:0] clip(input logic signed [W+1:0] v);
        logic signed [W+1:0] vmax;
        logic signed [W+1:0] vmin;
        logic [W:0]          res;
        vmax = (W+2)'({1'b0, {(W-1){1'b1}}});
        vmin = -vmax - (W+2)'(1);
        if (v > vmax) begin
            res = {1'b1, 1'b0, {(W-1){1'b1}}};
        end else if (v < vmin) begin
            res = {1'b1, 1'b1, {(W-1){1'b0}}};
        end else begin
            res = {1'b0, v[W-1:0]};
        end
        return res;
    endfunction

    logic en;
    logic accept;

    // configuration
    logic signed [OMEGA_WIDTH-1:0] r_omega;

    // window
    logic signed [W-1:0] r_centre;
    logic signed [W-1:0] r_behind;
    logic [1:0]          r_fill;
    logic [1:0]          fill_eff;

    // stage 1: differences
    logic                         r_v1;
    logic signed [DIFF_WIDTH-1:0] r_d1;
    logic signed [DIFF_WIDTH-1:0] r_d2;
    logic signed [W-1:0]          r_c1;

    // stage 2: magnitudes
    t_carry          r_k2;
    logic [W-1:0]    r_a2;

    // stage 3: weight products
    t_carry              r_k3;
    logic [W-1:0]        r_a3;
    logic [M_WIDTH-1:0]  r_p1;
    logic [M_WIDTH-1:0]  r_p2;

    // stage 4: blend
    t_carry              r_k4;
    logic [W-1:0]        r_a4;
    logic [M_WIDTH-1:0]  r_m;

    // stage 5: split product
    t_carry                 r_k5;
    logic [PROD_WIDTH-1:0]  r_plo;
    logic [PROD_WIDTH-1:0]  r_phi;

    // divider stages
    t_carry r_kd [QUOT_WIDTH+1];
    t_div   r_dv [QUOT_WIDTH+1];

    // output register
    logic                  r_out_valid;
    logic signed [W-1:0]   r_slope;
    logic signed [W-1:0]   r_left;
    logic signed [W-1:0]   r_right;
    logic                  r_sat;

    assign en       = !r_out_valid || !i_stall;
    assign o_stall  = !en;
    assign accept   = i_valid && en;
    assign fill_eff = i_row_start ? 2'd0 : r_fill;

    // omega register, clamped to +-1.0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_omega <= '0;
        end else if (i_omega_we) begin
            if (i_omega_wdata > OMEGA_ONE) begin
                r_omega <= OMEGA_ONE;
            end else if (i_omega_wdata < -OMEGA_ONE) begin
                r_omega <= -OMEGA_ONE;
            end else begin
                r_omega <= i_omega_wdata;
            end
        end
    end

    // window delay line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre <= '0;
            r_behind <= '0;
            r_fill   <= '0;
        end else if (accept) begin
            r_behind <= r_centre;
            r_centre <= i_sample;
            r_fill   <= (fill_eff == FILL_FULL) ? FILL_FULL : fill_eff + 2'd1;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= accept && (fill_eff == FILL_FULL);
        end
    end

    // front arithmetic stages
    logic [W-1:0]           a_abs;
    logic [W-1:0]           b_abs;
    logic [DIFF_WIDTH-1:0]  d1_neg;
    logic [DIFF_WIDTH-1:0]  d2_neg;
    logic [M_WIDTH-1:0]     w1x;
    logic [M_WIDTH-1:0]     w2x;
    logic [PROD_WIDTH-1:0]  prod;
    logic [X_WIDTH-1:0]     xval;

    always_comb begin
        d1_neg = -r_d1;
        d2_neg = -r_d2;
        a_abs  = r_d1[DIFF_WIDTH-1] ? d1_neg[W-1:0] : r_d1[W-1:0];
        b_abs  = r_d2[DIFF_WIDTH-1] ? d2_neg[W-1:0] : r_d2[W-1:0];
        w1x    = M_WIDTH'(unsigned'(OMEGA_WIDTH'(OMEGA_ONE + r_omega)));
        w2x    = M_WIDTH'(unsigned'(OMEGA_WIDTH'(OMEGA_ONE - r_omega)));
        prod   = (r_phi << MLO_WIDTH) + r_plo;
        xval   = prod[PROD_WIDTH-1:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k2.valid <= 1'b0;
            r_k3.valid <= 1'b0;
            r_k4.valid <= 1'b0;
            r_k5.valid <= 1'b0;
        end else if (en) begin
            r_k2.valid <= r_v1;
            r_k3.valid <= r_k2.valid;
            r_k4.valid <= r_k3.valid;
            r_k5.valid <= r_k4.valid;
            // stage 1
            r_d1 <= DIFF_WIDTH'(r_centre) - DIFF_WIDTH'(r_behind);
            r_d2 <= DIFF_WIDTH'(i_sample) - DIFF_WIDTH'(r_centre);
            r_c1 <= r_centre;
            // stage 2
            r_a2        <= a_abs;
            r_k2.ok     <= (r_d1 != '0) && (r_d2 != '0)
                           && (r_d1[DIFF_WIDTH-1] == r_d2[DIFF_WIDTH-1]);
            r_k2.neg    <= r_d2[DIFF_WIDTH-1];
            r_k2.centre <= r_c1;
            r_k2.b      <= b_abs;
            r_k2.s      <= SUM_WIDTH'(a_abs) + SUM_WIDTH'(b_abs);
            // stage 3
            r_k3.ok     <= r_k2.ok;
            r_k3.neg    <= r_k2.neg;
            r_k3.centre <= r_k2.centre;
            r_k3.b      <= r_k2.b;
            r_k3.s      <= r_k2.s;
            r_a3        <= r_a2;
            r_p1        <= w1x * M_WIDTH'(r_a2);
            r_p2        <= w2x * M_WIDTH'(r_k2.b);
            // stage 4
            r_k4.ok     <= r_k3.ok;
            r_k4.neg    <= r_k3.neg;
            r_k4.centre <= r_k3.centre;
            r_k4.b      <= r_k3.b;
            r_k4.s      <= r_k3.s;
            r_a4        <= r_a3;
            r_m         <= r_p1 + r_p2;
            // stage 5
            r_k5.ok     <= r_k4.ok;
            r_k5.neg    <= r_k4.neg;
            r_k5.centre <= r_k4.centre;
            r_k5.b      <= r_k4.b;
            r_k5.s      <= r_k4.s;
            r_plo       <= PROD_WIDTH'(r_m[MLO_WIDTH-1:0]) * PROD_WIDTH'(r_a4);
            r_phi       <= PROD_WIDTH'(r_m[M_WIDTH-1:MLO_WIDTH]) * PROD_WIDTH'(r_a4);
        end
    end

    // restoring divider, one quotient bit per stage
    logic [REM_WIDTH:0]   trial [QUOT_WIDTH];
    logic [REM_WIDTH:0]   diff  [QUOT_WIDTH];

    always_comb begin
        for (int k = 0; k < QUOT_WIDTH; k++) begin
            trial[k] = {r_dv[k].rem, r_dv[k].xlo[QUOT_WIDTH-1]};
            diff[k]  = trial[k] - (REM_WIDTH+1)'(r_kd[k].s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QUOT_WIDTH; k++) begin
                r_kd[k].valid <= 1'b0;
            end
        end else if (en) begin
            r_kd[0].valid  <= r_k5.valid;
            r_kd[0].ok     <= r_k5.ok;
            r_kd[0].neg    <= r_k5.neg;
            r_kd[0].centre <= r_k5.centre;
            r_kd[0].b      <= r_k5.b;
            r_kd[0].s      <= r_k5.s;
            r_dv[0].rem    <= REM_WIDTH'(xval[X_WIDTH-1:QUOT_WIDTH]);
            r_dv[0].xlo    <= xval[QUOT_WIDTH-1:0];
            r_dv[0].q      <= '0;
            for (int k = 0; k < QUOT_WIDTH; k++) begin
                r_kd[k+1].valid  <= r_kd[k].valid;
                r_kd[k+1].ok     <= r_kd[k].ok;
                r_kd[k+1].neg    <= r_kd[k].neg;
                r_kd[k+1].centre <= r_kd[k].centre;
                r_kd[k+1].b      <= r_kd[k].b;
                r_kd[k+1].s      <= r_kd[k].s;
                r_dv[k+1].xlo    <= r_dv[k].xlo << 1;
                if (!diff[k][REM_WIDTH] || (trial[k] >= (REM_WIDTH+1)'(r_kd[k].s))) begin
                    r_dv[k+1].rem <= diff[k][REM_WIDTH-1:0];
                    r_dv[k+1].q   <= {r_dv[k].q[QUOT_WIDTH-2:0], 1'b1};
                end else begin
                    r_dv[k+1].rem <= trial[k][REM_WIDTH-1:0];
                    r_dv[k+1].q   <= {r_dv[k].q[QUOT_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    // final stage: cap at |d2|, sign, edges, saturation
    t_carry                kf;
    logic [QUOT_WIDTH-1:0] qf;
    logic [W-1:0]          mag;
    logic signed [W+1:0]   slope_w;
    logic signed [W+1:0]   half_w;
    logic [W:0]            cs;
    logic [W:0]            cl;
    logic [W:0]            cr;

    always_comb begin
        kf  = r_kd[QUOT_WIDTH];
        qf  = r_dv[QUOT_WIDTH].q;
        if (!kf.ok) begin
            mag = '0;
        end else if (qf > QUOT_WIDTH'(kf.b)) begin
            mag = kf.b;
        end else begin
            mag = qf[W-1:0];
        end
        slope_w = kf.neg ? -signed'((W+2)'(mag)) : signed'((W+2)'(mag));
        half_w  = kf.neg ? -signed'((W+2)'(mag >> 1)) : signed'((W+2)'(mag >> 1));
        cs = clip(slope_w);
        cl = clip((W+2)'(kf.centre) - half_w);
        cr = clip((W+2)'(kf.centre) + half_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= kf.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_slope <= cs[W-1:0];
            r_left  <= cl[W-1:0];
            r_right <= cr[W-1:0];
            r_sat   <= cs[W] | cl[W] | cr[W];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_slope      = r_slope;
    assign o_left_edge  = r_left;
    assign o_right_edge = r_right;
    assign o_saturated  = r_sat;

endmodule

@@ tb/van_leer_limited_slope_reconstruction_unit_tb.sv @@
`timescale 1ns / 1ps

// expected slopes and edges, one per cell that has a full window
class slope_scoreboard;
    logic signed [31:0] exp_slope[$];
    logic signed [31:0] exp_left[$];
    logic signed [31:0] exp_right[$];
    logic               exp_sat[$];
    longint             centre_v;
    longint             behind_v;
    int                 fill;
    longint             omega_v;
    int                 errors;
    int                 checked;

    function void reset_state();
        centre_v = 0;
        behind_v = 0;
        fill     = 0;
        omega_v  = 0;
        errors   = 0;
        checked  = 0;
    endfunction

    function void set_omega(logic signed [15:0] w);
        longint v;
        v = w;
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        omega_v = v;
    endfunction

    // note one accepted cell value
    function void note_cell(logic signed [31:0] smp, logic rs);
        longint x, d1, d2, sl, hf, l, r;
        longint w1, w2;
        logic [127:0] a, b, m, q;
        bit hit;
        x = smp;
        if (rs) fill = 0;
        if (fill >= 2) begin
            d1 = centre_v - behind_v;
            d2 = x - centre_v;
            sl = 0;
            if (d1 != 0 && d2 != 0 && ((d1 > 0) == (d2 > 0))) begin
                a = (d1 < 0) ? -d1 : d1;
                b = (d2 < 0) ? -d2 : d2;
                // weights are never negative, so they widen safely
                w1 = 16384 + omega_v;
                w2 = 16384 - omega_v;
                m = w1 * a + w2 * b;
                q = ((m * 2 * a) / (a + b)) >> 15;
                if (q > b) q = b;
                sl = (d2 > 0) ? longint'(q) : -longint'(q);
            end
            hf = (sl < 0) ? -((-sl) >>> 1) : (sl >>> 1);
            hit = 0;
            l = centre_v - hf;
            r = centre_v + hf;
            if (sl > 64'sd2147483647) begin sl = 2147483647; hit = 1; end
            if (sl < -64'sd2147483648) begin sl = -2147483648; hit = 1; end
            if (l > 64'sd2147483647) begin l = 2147483647; hit = 1; end
            if (l < -64'sd2147483648) begin l = -2147483648; hit = 1; end
            if (r > 64'sd2147483647) begin r = 2147483647; hit = 1; end
            if (r < -64'sd2147483648) begin r = -2147483648; hit = 1; end
            exp_slope.push_back(sl[31:0]);
            exp_left.push_back(l[31:0]);
            exp_right.push_back(r[31:0]);
            exp_sat.push_back(hit);
        end
        behind_v = centre_v;
        centre_v = x;
        if (fill < 2) fill++;
    endfunction

    function void check_result(logic signed [31:0] sl, logic signed [31:0] l,
                               logic signed [31:0] r, logic sat);
        logic signed [31:0] es, el, er;
        logic               esat;
        if (exp_slope.size() == 0) begin
            $display("%0t: unexpected result slope %0d", $time, sl);
            errors++;
            return;
        end
        es = exp_slope.pop_front();
        el = exp_left.pop_front();
        er = exp_right.pop_front();
        esat = exp_sat.pop_front();
        checked++;
        if (sl !== es) begin
            $display("%0t: slope expected %0d actual %0d", $time, es, sl);
            errors++;
        end
        if (l !== el) begin
            $display("%0t: left_edge expected %0d actual %0d", $time, el, l);
            errors++;
        end
        if (r !== er) begin
            $display("%0t: right_edge expected %0d actual %0d", $time, er, r);
            errors++;
        end
        if (sat !== esat) begin
            $display("%0t: saturated expected %0b actual %0b", $time, esat, sat);
            errors++;
        end
    endfunction
endclass

module van_leer_limited_slope_reconstruction_unit_tb;
    import vlsr_pkg::*;

    localparam int LATENCY = 40;
    localparam longint CYCLE_LIMIT = 400000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_omega_we = 1'b0;
    logic signed [OMEGA_WIDTH-1:0]  i_omega_wdata = '0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic signed [SAMPLE_WIDTH-1:0] i_sample = '0;
    logic                           i_row_start = 1'b0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] o_slope;
    logic signed [SAMPLE_WIDTH-1:0] o_left_edge;
    logic signed [SAMPLE_WIDTH-1:0] o_right_edge;
    logic                           o_saturated;

    slope_scoreboard sb;
    longint cycles = 0;
    int     cells_sent = 0;
    // idle percentages for sender and receiver
    int     send_idle = 0;
    int     recv_idle = 0;

    van_leer_limited_slope_reconstruction_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_omega_we   (i_omega_we),
        .i_omega_wdata(i_omega_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .i_row_start  (i_row_start),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_slope      (o_slope),
        .o_left_edge  (o_left_edge),
        .o_right_edge (o_right_edge),
        .o_saturated  (o_saturated)
    );

    always #5 i_clk = ~i_clk;

    // result check and timeout, sampled at the rising edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_slope, o_left_edge, o_right_edge, o_saturated);
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall, changed at the falling edge
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle);
    end

    // send one cell beat, with random idle cycles before it; valid stays high
    // afterwards until the next beat or an idle cycle drops it
    task automatic send_cell(logic signed [31:0] smp, logic rs);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample    <= smp;
        i_row_start <= rs;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_cell(smp, rs);
        cells_sent++;
        @(negedge i_clk);
    endtask

    // drain the pipe, then let the latency pass before a register write
    task automatic drain_and_write(logic signed [15:0] w);
        i_valid <= 1'b0;
        while (sb.exp_slope.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
        i_omega_we    <= 1'b1;
        i_omega_wdata <= w;
        @(negedge i_clk);
        i_omega_we <= 1'b0;
        sb.set_omega(w);
    endtask

    function automatic logic signed [31:0] rand_sample(int mode);
        logic signed [31:0] v;
        case (mode)
            0: v = $urandom;
            1: v = $signed($urandom_range(2000)) - 1000;
            default: v = ($urandom_range(1) ? 32'sh7fff0000 : 32'sh80010000)
                         + $signed($urandom_range(65535)) - 32768;
        endcase
        return v;
    endfunction

    // rows of smooth-ish data, sometimes wild
    task automatic send_rows(int n);
        logic signed [31:0] base, step;
        int mode, k;
        k = 0;
        while (k < n) begin
            mode = $urandom_range(9);
            base = $urandom;
            step = $signed($urandom) >>> $urandom_range(31);
            send_cell(base, 1'b1);
            k++;
            repeat ($urandom_range(30, 2)) begin
                if (mode < 6) begin
                    // monotone with random curvature
                    base = base + step;
                    step = step + ($signed($urandom) >>> $urandom_range(31, 8));
                    send_cell(base, 1'b0);
                end else if (mode < 8) begin
                    send_cell(rand_sample($urandom_range(2)), 1'b0);
                end else begin
                    send_cell(rand_sample(0), $urandom_range(7) == 0);
                end
                k++;
            end
        end
    endtask

    initial begin
        logic signed [15:0] omegas[6];
        sb = new();
        sb.reset_state();
        omegas = '{16'sd16384, -16'sd16384, 16'sh7fff, 16'sh8000, 16'sd5000, 16'sd0};
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, flat, sign change, row restart, values near full scale
        send_cell(32'sh80000000, 1'b1);
        send_cell(32'sh7fffffff, 1'b0);
        send_cell(32'sh80000000, 1'b0);
        send_cell(32'sh80000000, 1'b0);
        send_cell(32'sh80000000, 1'b0);
        send_cell(32'sd0, 1'b1);
        send_cell(32'sd65536, 1'b0);
        send_cell(32'sd131072, 1'b0);
        send_cell(32'sd131072, 1'b0);
        send_cell(32'sd65536, 1'b0);
        send_cell(32'sd0, 1'b0);
        send_cell(-32'sd1, 1'b0);
        send_cell(32'sd0, 1'b1);
        send_cell(32'sh40000000, 1'b0);
        send_cell(32'sh7fffffff, 1'b0);
        send_cell(32'sd0, 1'b1);
        send_cell(-32'sh40000000, 1'b0);
        send_cell(32'sh80000000, 1'b0);
        send_cell(32'sh7ffffff0, 1'b0);
        send_cell(32'sh7ffffff8, 1'b0);
        send_cell(32'sh7fffffff, 1'b0);

        for (int ph = 0; ph < 6; ph++) begin
            drain_and_write(omegas[ph]);
            send_idle = (ph < 2) ? 34 : (ph < 4) ? 65 : 0;
            recv_idle = (ph < 2) ? 65 : (ph < 4) ? 34 : 0;
            send_rows(280);
        end
        send_idle = 0;
        recv_idle = 0;
        i_valid <= 1'b0;

        while (sb.exp_slope.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("sent %0d cells over six omega settings, %0d results checked",
                 cells_sent, sb.checked);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
rtl/vlsr_pkg.sv
rtl/van_leer_limited_slope_reconstruction_unit.sv
tb/van_leer_limited_slope_reconstruction_unit_tb.sv
